/* design/self_triggered_event_builder_defines.svh */
// Assertion macros shared by the event builder modules.
`ifndef SELF_TRIGGERED_EVENT_BUILDER_DEFINES_SVH
`define SELF_TRIGGERED_EVENT_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, muted in reset.
`define EVB_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, muted in reset.
`define EVB_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/evb_pkg.sv */
// Shared constants and types of the event builder.
package evb_pkg;

   // default sizing
   localparam int NUM_CHANNELS_DEF = 36;
   localparam int TIME_BITS_DEF    = 48;
   localparam int ENERGY_BITS_DEF  = 16;

   // fixed field widths
   localparam int CHAN_BITS     = 6;
   localparam int WINDOW_BITS   = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register map: index is paddr[2]
   localparam logic REG_WINDOW = 1'b0;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 32'd100;

   // item actions
   localparam logic ACTION_HIT   = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   typedef struct packed {
      logic [WINDOW_BITS-1:0] window_ticks;
   } cfg_type;

endpackage

/* design/evb_req_if.sv */
// Hit channel: one beat is one hit or one flush request.
interface evb_req_if #(
   parameter int TIME_BITS   = evb_pkg::TIME_BITS_DEF,
   parameter int ENERGY_BITS = evb_pkg::ENERGY_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic                          hit_valid;
   logic [evb_pkg::CHAN_BITS-1:0] channel;
   logic [TIME_BITS-1:0]          hit_time;
   logic [ENERGY_BITS-1:0]        hit_energy;

   modport source (output valid, action, hit_valid, channel, hit_time, hit_energy,
                   input ready);
   modport sink   (input valid, action, hit_valid, channel, hit_time, hit_energy,
                   output ready);
endinterface

/* design/evb_rsp_if.sv */
// Result channel: one beat is one channel of an emitted event.
interface evb_rsp_if #(
   parameter int NUM_CHANNELS = evb_pkg::NUM_CHANNELS_DEF,
   parameter int TIME_BITS    = evb_pkg::TIME_BITS_DEF,
   parameter int ENERGY_BITS  = evb_pkg::ENERGY_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic [evb_pkg::CHAN_BITS-1:0] out_channel;
   logic [TIME_BITS-1:0]          out_time;
   logic [ENERGY_BITS-1:0]        out_energy;
   logic [NUM_CHANNELS-1:0]       event_mask;
   logic                          last;

   modport source (output valid, out_channel, out_time, out_energy, event_mask, last,
                   input ready);
   modport sink   (input valid, out_channel, out_time, out_energy, event_mask, last,
                   output ready);
endinterface

/* design/self_triggered_event_builder.sv */
// Coincidence-window event builder: groups time-ordered hits into events.
// Channels: req_ch carries one hit or one flush per beat; rsp_ch carries one
// beat per hit channel of an emitted event, in ascending channel order, with
// last set on the final beat and event_mask identical on every beat.
// csr_* is an APB-style port holding window_ticks at byte address 0.
// Sequencing: a hit that opens or joins an event is read from the store on
// acceptance, then compared and written back through the store write port.
// A hit outside the window, or a flush, then walks the event: for each hit
// channel a store read (ST_EMIT_RD), then an output load (ST_EMIT_WR); a
// closing hit passes ST_CHECK first, a flush goes straight to the walk.
// Ignored items (invalid hit, channel out of range, empty flush) leave the block idle.
// The first result beat is loaded into the output register in ST_EMIT_WR,
// after the store read of ST_EMIT_RD.
// Reset: hit mask and reference time clear at once, window_ticks returns to
// 100; the channel store needs no clearing since only masked entries are read.
// Stall: a result beat waits in the output register; the walk pauses until it
// is taken, and the next item is accepted while the final beat still waits.
module self_triggered_event_builder #(
   parameter int NUM_CHANNELS = evb_pkg::NUM_CHANNELS_DEF,
   parameter int TIME_BITS    = evb_pkg::TIME_BITS_DEF,
   parameter int ENERGY_BITS  = evb_pkg::ENERGY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   evb_req_if.sink                           req_ch,
   evb_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [evb_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [evb_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [evb_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   evb_pkg::cfg_type cfg;

   evb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   evb_engine #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .TIME_BITS    (TIME_BITS),
      .ENERGY_BITS  (ENERGY_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );
endmodule

/* design/evb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module evb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [ADDR_BITS-1:0]  waddr,
   input  logic [WIDTH-1:0]      wdata,
   input  logic                  re,
   input  logic [ADDR_BITS-1:0]  raddr,
   output logic [WIDTH-1:0]      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port, and read port holding its last word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* design/evb_csr.sv */
// Register file: the coincidence window behind an APB-style port.
module evb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [evb_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [evb_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [evb_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready,
   output evb_pkg::cfg_type                  cfg
);
   logic [evb_pkg::WINDOW_BITS-1:0] window_ff;
   logic [evb_pkg::WINDOW_BITS-1:0] window_in;
   logic                            reg_index;
   logic                            wr_strobe;

   assign reg_index  = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // take the write on the access phase
   always_comb begin
      window_in = window_ff;
      if (wr_strobe && (reg_index == evb_pkg::REG_WINDOW)) begin
         window_in = csr_pwdata[evb_pkg::WINDOW_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= evb_pkg::WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (reg_index == evb_pkg::REG_WINDOW) begin
         csr_prdata = evb_pkg::CSR_DATA_BITS'(window_ff);
      end
   end

   assign cfg.window_ticks = window_ff;
endmodule

/* design/evb_engine.sv */
// Event engine: hit mask, reference time and channel store read-modify-write.
`include "self_triggered_event_builder_defines.svh"

module evb_engine #(
   parameter int NUM_CHANNELS = evb_pkg::NUM_CHANNELS_DEF,
   parameter int TIME_BITS    = evb_pkg::TIME_BITS_DEF,
   parameter int ENERGY_BITS  = evb_pkg::ENERGY_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  evb_pkg::cfg_type cfg,
   evb_req_if.sink          req_ch,
   evb_rsp_if.source        rsp_ch
);
   localparam int ADDR_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int WORD_BITS = TIME_BITS + ENERGY_BITS;
   localparam int CMP_BITS  = (TIME_BITS > evb_pkg::WINDOW_BITS) ? TIME_BITS
                                                                 : evb_pkg::WINDOW_BITS;
   localparam logic [evb_pkg::CHAN_BITS:0] CHAN_LIMIT = (evb_pkg::CHAN_BITS + 1)'(NUM_CHANNELS);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CHECK   = 2'd1;
   localparam logic [1:0] ST_EMIT_RD = 2'd2;
   localparam logic [1:0] ST_EMIT_WR = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [NUM_CHANNELS-1:0]       mask_ff, mask_in;
   logic [NUM_CHANNELS-1:0]       remain_ff, remain_in;
   logic [TIME_BITS-1:0]          ref_ff, ref_in;
   logic                          pend_ff, pend_in;
   logic [evb_pkg::CHAN_BITS-1:0] emit_ch_ff, emit_ch_in;
   logic                          emit_last_ff, emit_last_in;

   // held item
   logic [evb_pkg::CHAN_BITS-1:0] ch_ff;
   logic [TIME_BITS-1:0]          time_ff;
   logic [ENERGY_BITS-1:0]        energy_ff;

   // output register
   logic                          rsp_valid_ff;
   logic [evb_pkg::CHAN_BITS-1:0] out_ch_ff;
   logic [TIME_BITS-1:0]          out_time_ff;
   logic [ENERGY_BITS-1:0]        out_energy_ff;
   logic [NUM_CHANNELS-1:0]       out_mask_ff;
   logic                          out_last_ff;

   logic                          req_accept;
   logic                          in_range;
   logic                          out_free;
   logic                          load_out;
   logic [NUM_CHANNELS-1:0]       item_bit;
   logic [NUM_CHANNELS-1:0]       low_bit;
   logic [evb_pkg::CHAN_BITS-1:0] low_idx;
   logic [TIME_BITS-1:0]          diff;
   logic                          joins;
   logic                          keep;

   logic                          ram_we;
   logic                          ram_re;
   logic [ADDR_BITS-1:0]          ram_raddr;
   logic [WORD_BITS-1:0]          ram_rdata;
   logic [TIME_BITS-1:0]          rd_time;
   logic [ENERGY_BITS-1:0]        rd_energy;

   evb_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_CHANNELS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ch_ff[ADDR_BITS-1:0]),
      .wdata ({time_ff, energy_ff}),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_time   = ram_rdata[WORD_BITS-1:ENERGY_BITS];
   assign rd_energy = ram_rdata[ENERGY_BITS-1:0];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign in_range     = ({1'b0, req_ch.channel} < CHAN_LIMIT);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // window test of the held hit against the reference
   assign item_bit = NUM_CHANNELS'(1) << ch_ff;
   assign diff     = time_ff - ref_ff;
   assign joins    = diff[TIME_BITS-1] ||
                     (CMP_BITS'(diff) < CMP_BITS'(cfg.window_ticks));
   assign keep     = ((mask_ff & item_bit) == '0) || (energy_ff > rd_energy);

   // lowest channel still to emit
   assign low_bit = remain_ff & (~remain_ff + NUM_CHANNELS'(1));
   always_comb begin
      low_idx = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | evb_pkg::CHAN_BITS'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      remain_in    = remain_ff;
      ref_in       = ref_ff;
      pend_in      = pend_ff;
      emit_ch_in   = emit_ch_ff;
      emit_last_in = emit_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = req_ch.channel[ADDR_BITS-1:0];
      load_out     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_ch.action == evb_pkg::ACTION_FLUSH) begin
                  if (mask_ff != '0) begin
                     remain_in = mask_ff;
                     pend_in   = 1'b0;
                     state_in  = ST_EMIT_RD;
                  end
               end else if (req_ch.hit_valid && in_range) begin
                  ram_re   = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (mask_ff == '0) begin
               // open a new event
               ram_we   = 1'b1;
               mask_in  = item_bit;
               ref_in   = time_ff;
               state_in = ST_IDLE;
            end else if (joins) begin
               // join: keep the first hit, replace on strictly greater energy
               if (keep) begin
                  ram_we  = 1'b1;
                  mask_in = mask_ff | item_bit;
               end
               state_in = ST_IDLE;
            end else begin
               // close the open event, hold the hit until it is out
               remain_in = mask_ff;
               pend_in   = 1'b1;
               state_in  = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            ram_re       = 1'b1;
            ram_raddr    = low_idx[ADDR_BITS-1:0];
            emit_ch_in   = low_idx;
            remain_in    = remain_ff & ~low_bit;
            emit_last_in = ((remain_ff & ~low_bit) == '0);
            state_in     = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (out_free) begin
               load_out = 1'b1;
               if (emit_last_ff) begin
                  // drop the event, then open the held hit if there is one
                  mask_in  = '0;
                  state_in = ST_IDLE;
                  if (pend_ff) begin
                     ram_we  = 1'b1;
                     mask_in = item_bit;
                     ref_in  = time_ff;
                     pend_in = 1'b0;
                  end
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         remain_ff    <= '0;
         ref_ff       <= '0;
         pend_ff      <= 1'b0;
         emit_ch_ff   <= '0;
         emit_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         remain_ff    <= remain_in;
         ref_ff       <= ref_in;
         pend_ff      <= pend_in;
         emit_ch_ff   <= emit_ch_in;
         emit_last_ff <= emit_last_in;
      end
   end

   // hold the accepted beat
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ch_ff     <= req_ch.channel;
         time_ff   <= req_ch.hit_time;
         energy_ff <= req_ch.hit_energy;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ch_ff     <= emit_ch_ff;
         out_time_ff   <= rd_time;
         out_energy_ff <= rd_energy;
         out_mask_ff   <= mask_ff;
         out_last_ff   <= emit_last_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_channel = out_ch_ff;
   assign rsp_ch.out_time    = out_time_ff;
   assign rsp_ch.out_energy  = out_energy_ff;
   assign rsp_ch.event_mask  = out_mask_ff;
   assign rsp_ch.last        = out_last_ff;

   `EVB_CHECK(a_store_write_state, ram_we, (state_ff == ST_CHECK) || (state_ff == ST_EMIT_WR), "store written outside update or event close")
   `EVB_CHECK(a_remain_in_mask, state_ff == ST_EMIT_RD, ((remain_ff & ~mask_ff) == '0) && (remain_ff != '0), "emit walk outside the hit mask")
   `EVB_CHECK_NEXT(a_last_to_idle, (state_ff == ST_EMIT_WR) && out_free && emit_last_ff, state_ff == ST_IDLE, "event close did not return to idle")
   `EVB_CHECK_NEXT(a_mask_held_in_walk, state_ff == ST_EMIT_RD, mask_ff == $past(mask_ff), "hit mask moved during emission")
endmodule

/* tb/event_window_checker.sv */
// Event builder checker: predicts the beats of every emitted event and compares them.
module event_window_checker
   import evb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   evb_req_if                       req_ch,
   evb_rsp_if                       rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                       mismatch_count,
   output int                       pending
);

   localparam int NUM_CH   = NUM_CHANNELS_DEF;
   localparam int TIME_W   = TIME_BITS_DEF;
   localparam int ENERGY_W = ENERGY_BITS_DEF;

   typedef struct packed {
      logic [CHAN_BITS-1:0] channel;
      logic [TIME_W-1:0]    stamp;
      logic [ENERGY_W-1:0]  energy;
      logic [NUM_CH-1:0]    mask;
      logic                 last;
   } event_beat_t;

   event_beat_t          expected_beats [$];
   logic [NUM_CH-1:0]    hit_set;
   logic [TIME_W-1:0]    kept_time   [NUM_CH];
   logic [ENERGY_W-1:0]  kept_energy [NUM_CH];
   logic [TIME_W-1:0]    event_start;
   logic [WINDOW_BITS-1:0] window_len;
   int                   errors = 0;

   // count every mismatch and print one line for each of the first 200
   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 200) begin
         $display("%0t mismatch: %s", $time, msg);
      end
   endtask

   // keep the first hit of a channel, replace it only on strictly greater energy
   function automatic void keep_hit(input int unsigned chan, input logic [TIME_W-1:0] stamp,
                                    input logic [ENERGY_W-1:0] energy);
      if (!hit_set[chan] || energy > kept_energy[chan]) begin
         hit_set[chan]     = 1'b1;
         kept_time[chan]   = stamp;
         kept_energy[chan] = energy;
      end
   endfunction

   // queue one beat per hit channel in ascending order, then empty the store
   function automatic void close_event();
      event_beat_t beat;
      int          top_chan;
      top_chan = -1;
      for (int c = 0; c < NUM_CH; c++) begin
         if (hit_set[c]) top_chan = c;
      end
      for (int c = 0; c < NUM_CH; c++) begin
         if (hit_set[c]) begin
            beat.channel = CHAN_BITS'(c);
            beat.stamp   = kept_time[c];
            beat.energy  = kept_energy[c];
            beat.mask    = hit_set;
            beat.last    = (c == top_chan);
            expected_beats.push_back(beat);
         end
      end
      hit_set = '0;
   endfunction

   // advance the event state by one accepted item
   function automatic void predict_item(input logic action, input logic valid_bit,
                                        input logic [CHAN_BITS-1:0] chan,
                                        input logic [TIME_W-1:0] stamp,
                                        input logic [ENERGY_W-1:0] energy);
      logic [TIME_W-1:0] offset;
      if (action == ACTION_FLUSH) begin
         close_event();
         return;
      end
      if (!valid_bit || chan >= NUM_CH) return;
      if (hit_set == '0) begin
         keep_hit(chan, stamp, energy);
         event_start = stamp;
         return;
      end
      // a negative offset counts as inside the window
      offset = stamp - event_start;
      if (!offset[TIME_W-1] && offset >= TIME_W'(window_len)) begin
         close_event();
         event_start = stamp;
      end
      keep_hit(chan, stamp, energy);
   endfunction

   // compare one result beat with the oldest expectation
   task automatic check_beat();
      event_beat_t want;
      if (expected_beats.size() == 0) begin
         report_mismatch($sformatf("beat on channel %0d with no event pending",
                                   rsp_ch.out_channel));
         return;
      end
      want = expected_beats.pop_front();
      if (rsp_ch.out_channel !== want.channel)
         report_mismatch($sformatf("out_channel %0d, expected %0d",
                                   rsp_ch.out_channel, want.channel));
      if (rsp_ch.out_time !== want.stamp)
         report_mismatch($sformatf("channel %0d out_time %0h, expected %0h",
                                   want.channel, rsp_ch.out_time, want.stamp));
      if (rsp_ch.out_energy !== want.energy)
         report_mismatch($sformatf("channel %0d out_energy %0h, expected %0h",
                                   want.channel, rsp_ch.out_energy, want.energy));
      if (rsp_ch.event_mask !== want.mask)
         report_mismatch($sformatf("channel %0d event_mask %0h, expected %0h",
                                   want.channel, rsp_ch.event_mask, want.mask));
      if (rsp_ch.last !== want.last)
         report_mismatch($sformatf("channel %0d last %0b, expected %0b",
                                   want.channel, rsp_ch.last, want.last));
   endtask

   // watch both channels and the register port at every edge
   always @(posedge clock) begin
      if (reset) begin
         hit_set     = '0;
         event_start = '0;
         window_len  = WINDOW_RESET;
         expected_beats.delete();
      end else begin
         // a beat leaving now always belongs to an event already predicted
         if (rsp_ch.valid && rsp_ch.ready) check_beat();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[2] == REG_WINDOW)
            window_len = csr_pwdata[WINDOW_BITS-1:0];
         if (req_ch.valid && req_ch.ready)
            predict_item(req_ch.action, req_ch.hit_valid, req_ch.channel,
                         req_ch.hit_time, req_ch.hit_energy);
      end
      pending        <= expected_beats.size();
      mismatch_count <= errors;
   end

endmodule

/* tb/self_triggered_event_builder_tb.sv */
// Testbench top: drives hits, flushes and window writes and gives the verdict.
module self_triggered_event_builder_tb;
   import evb_pkg::*;

   localparam int NUM_CH       = NUM_CHANNELS_DEF;
   localparam int TIME_W       = TIME_BITS_DEF;
   localparam int ENERGY_W     = ENERGY_BITS_DEF;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS  = 12;
   localparam logic [CSR_ADDR_BITS-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       mismatches;
   int                       pending;
   int                       req_idle_pct;
   int                       rsp_idle_pct;
   logic                     hold_request;
   int                       cycle_count = 0;
   logic [TIME_W-1:0]        event_ref;
   logic [WINDOW_BITS-1:0]   window_now;

   evb_req_if req_ch ();
   evb_rsp_if rsp_ch ();

   self_triggered_event_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   event_window_checker window_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatches),
      .pending        (pending)
   );

   // clock: period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic logic [TIME_W-1:0] random_stamp();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[TIME_W-1:0];
   endfunction

   // favour the energy extremes now and then
   function automatic logic [ENERGY_W-1:0] pick_energy();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return ENERGY_W'($urandom);
   endfunction

   // offer one beat, idling first at random, and hold it until accepted
   task automatic send_item(input logic action, input logic valid_bit,
                            input logic [CHAN_BITS-1:0] chan, input logic [TIME_W-1:0] stamp,
                            input logic [ENERGY_W-1:0] energy);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= action;
      req_ch.hit_valid  <= valid_bit;
      req_ch.channel    <= chan;
      req_ch.hit_time   <= stamp;
      req_ch.hit_energy <= energy;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_hit(input logic [CHAN_BITS-1:0] chan, input logic [TIME_W-1:0] stamp,
                           input logic [ENERGY_W-1:0] energy);
      send_item(ACTION_HIT, 1'b1, chan, stamp, energy);
   endtask

   // a flush ignores every other field, so fill them with noise
   task automatic send_flush();
      send_item(ACTION_FLUSH, 1'($urandom_range(1)), CHAN_BITS'($urandom_range(63)),
                random_stamp(), pick_energy());
   endtask

   // drop valid and wait until every expected beat has left and the block is idle
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write: setup phase, then access phase
   task automatic write_window(input logic [WINDOW_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WINDOW_ADDR;
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      window_now = value;
   endtask

   // extremes and corner cases at the reset window of 100 ticks
   task automatic run_directed();
      send_flush();
      send_item(ACTION_HIT, 1'b0, '1, '1, '1);
      send_item(ACTION_HIT, 1'b1, 6'd63, 48'd5, 16'd9);
      send_item(ACTION_HIT, 1'b1, 6'd36, 48'd7, 16'd9);
      send_hit(6'd0, 48'd1000, 16'd0);
      send_hit(6'd35, 48'd1099, 16'hFFFF);
      // equal energy keeps the first hit, greater energy replaces it
      send_hit(6'd0, 48'd1050, 16'd0);
      send_hit(6'd0, 48'd1060, 16'd5);
      send_hit(6'd35, 48'd1010, 16'hFFFF);
      // earlier than the reference: joins
      send_hit(6'd7, 48'd900, 16'h1234);
      send_item(ACTION_HIT, 1'b1, 6'd40, 48'd5000, 16'd1);
      send_item(ACTION_HIT, 1'b0, 6'd1, 48'd5000, 16'd1);
      // exactly one window after the reference: closes the event
      send_hit(6'd1, 48'd1100, 16'h00AA);
      send_item(ACTION_FLUSH, 1'b0, '1, '1, '1);
      send_flush();
      // wrap of the time counter joins, a huge jump closes, a wrapped back step joins
      send_hit(6'd20, 48'hFFFF_FFFF_FFF0, 16'h8000);
      send_hit(6'd21, 48'h0000_0000_0010, 16'h7FFF);
      send_hit(6'd22, 48'h7FFF_0000_0000, 16'h0001);
      send_hit(6'd23, 48'h0000_0000_0000, 16'hFFFE);
      send_item(ACTION_FLUSH, 1'b1, 6'd0, '0, '0);
   endtask

   // one hit of the event that starts at event_ref, now and then noise
   task automatic send_event_hit(input bit opener);
      int                   roll;
      logic [CHAN_BITS-1:0] chan;
      logic [TIME_W-1:0]    stamp;
      roll  = opener ? 99 : $urandom_range(99);
      chan  = ($urandom_range(9) < 3) ? CHAN_BITS'($urandom_range(3))
                                      : CHAN_BITS'($urandom_range(NUM_CH - 1));
      stamp = event_ref + $urandom_range(window_now - 1);
      if ($urandom_range(7) == 0) stamp = event_ref + window_now - 1;
      if (opener) stamp = event_ref;
      if (roll < 8) begin
         send_item(ACTION_HIT, 1'b0, CHAN_BITS'($urandom_range(63)), random_stamp(),
                   pick_energy());
      end else if (roll < 14) begin
         send_item(ACTION_HIT, 1'b1, CHAN_BITS'($urandom_range(63, NUM_CH)), random_stamp(),
                   pick_energy());
      end else if (roll < 20) begin
         send_hit(chan, event_ref - $urandom_range(1000, 1), pick_energy());
      end else begin
         send_hit(chan, stamp, pick_energy());
      end
   endtask

   // well-formed events with random content, separated by flushes and jumps
   task automatic run_events(input int count);
      int sent;
      int hits;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(11) == 0) begin
            send_flush();
            event_ref = random_stamp();
            sent++;
         end
         hits = ($urandom_range(7) == 0) ? $urandom_range(20, 8) : $urandom_range(5, 1);
         for (int k = 0; k < hits; k++) send_event_hit(k == 0);
         sent += hits;
         if ($urandom_range(9) == 0) begin
            send_flush();
            sent++;
         end
         // next opener lands on or beyond the window edge
         event_ref = event_ref + window_now +
                     (($urandom_range(3) == 0) ? 0 : $urandom_range(5000));
      end
   endtask

   // every channel hit once, in shuffled order, inside one window
   task automatic send_full_event();
      logic [CHAN_BITS-1:0] order [NUM_CH];
      logic [CHAN_BITS-1:0] swap;
      int                   pick;
      for (int c = 0; c < NUM_CH; c++) order[c] = CHAN_BITS'(c);
      for (int c = NUM_CH - 1; c > 0; c--) begin
         pick        = $urandom_range(c);
         swap        = order[c];
         order[c]    = order[pick];
         order[pick] = swap;
      end
      for (int c = 0; c < NUM_CH; c++) begin
         send_hit(order[c], (c == 0) ? event_ref : event_ref + $urandom_range(window_now - 1),
                  pick_energy());
      end
      event_ref = event_ref + window_now;
   endtask

   // main sequence
   initial begin
      reset             <= 1'b1;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.action     <= ACTION_HIT;
      req_ch.hit_valid  <= 1'b0;
      req_ch.channel    <= '0;
      req_ch.hit_time   <= '0;
      req_ch.hit_energy <= '0;
      hold_request      <= 1'b0;
      req_idle_pct      <= 28;
      rsp_idle_pct      <= 78;
      window_now = WINDOW_RESET;
      event_ref  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // narrowest window: only hits at or before the reference time join
      settle();
      write_window(32'd1);
      event_ref = random_stamp();
      run_events(PHASE_ITEMS);

      // widest window, roles of the stalls swapped
      settle();
      write_window('1);
      req_idle_pct <= 78;
      rsp_idle_pct <= 28;
      run_events(PHASE_ITEMS);

      settle();
      write_window(WINDOW_BITS'($urandom_range(1_000_000, 2)));
      run_events(PHASE_ITEMS);

      // no idling on either side
      settle();
      write_window(32'd1000);
      req_idle_pct <= 0;
      rsp_idle_pct <= 0;
      run_events(PHASE_ITEMS);

      // long hold-off on the result side: a full event closes into it while hits keep coming
      settle();
      hold_request <= 1'b1;
      send_full_event();
      for (int k = 0; k < 4; k++) begin
         send_hit(CHAN_BITS'($urandom_range(NUM_CH - 1)), event_ref, pick_energy());
      end
      send_flush();

      settle();
      if (mismatches == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* self_triggered_event_builder.f */
+incdir+design
design/evb_pkg.sv
design/evb_req_if.sv
design/evb_rsp_if.sv
design/evb_ram.sv
design/evb_csr.sv
design/evb_engine.sv
design/self_triggered_event_builder.sv
tb/event_window_checker.sv
tb/self_triggered_event_builder_tb.sv
